// File: hw/rtl/tdc_pkg.sv
// Shared types, widths and a saturation helper function for the transform decomposition block.
package tdc_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int THR_WIDTH   = 16;
    localparam int SCALE_WIDTH = DATA_WIDTH - 1;
    localparam int ROOT_BITS   = DATA_WIDTH + 1;
    localparam int QUOT_BITS   = 18;
    localparam int QUOT_WIDTH  = QUOT_BITS + 1;
    localparam int UP_WIDTH    = 2 * QUOT_WIDTH + 1 - FRAC_BITS;
    localparam int RIGHT_WIDTH = 2 * UP_WIDTH + 1 - FRAC_BITS;
    localparam int DOT_SHIFT   = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 0;
    localparam int ROW_WIDTH   = 2;

    localparam logic [ROW_WIDTH-1:0] ROW_X = 2'd0;
    localparam logic [ROW_WIDTH-1:0] ROW_Y = 2'd1;
    localparam logic [ROW_WIDTH-1:0] ROW_Z = 2'd2;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        t_data a00;
        t_data a01;
        t_data a02;
        t_data a10;
        t_data a11;
        t_data a12;
        t_data a20;
        t_data a21;
        t_data a22;
        t_data tx;
        t_data ty;
        t_data tz;
    } t_req;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] row;
        t_data                rot_x;
        t_data                rot_y;
        t_data                rot_z;
        t_data                scale_out;
        t_data                trans_out;
        logic                 ok;
        logic                 last;
    } t_result;

    // Clamp a wide signed value into the data width.
    function automatic t_data sat_data(input logic signed [63:0] v);
        t_data res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            res = v[DATA_WIDTH-1:0];
        end
        return res;
    endfunction

    localparam t_data ROT_ONE = sat_data(64'sd1 <<< FRAC_BITS);

endpackage

// File: hw/rtl/tdc_delay.sv
// Fixed-depth register delay line for datapath side values.
module tdc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

// File: hw/rtl/tdc_row_len.sv
// One row lane: exact sum of squares and a pipelined bit-per-stage square root.
module tdc_row_len (
    input  logic                             i_clk,
    input  tdc_pkg::t_data                   i_x [3],
    output logic [tdc_pkg::SCALE_WIDTH-1:0]  o_len
);
    import tdc_pkg::*;

    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int RAD_W = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS + 2;

    logic [DATA_WIDTH-1:0] mag [3];
    logic [SQ_W-1:0]       r_sq [3];
    logic [SQ_W-1:0]       r_sum;
    logic [REM_W-1:0]      r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0]  r_root [ROOT_BITS];
    logic [RAD_W-1:0]      r_rad  [ROOT_BITS];
    logic [REM_W-1:0]      n_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0]  n_root [ROOT_BITS];
    logic [RAD_W-1:0]      n_rad  [ROOT_BITS];
    logic [ROOT_BITS-1:0]  root;

    for (genvar i = 0; i < 3; i++) begin : g_mag
        assign mag[i] = i_x[i][DATA_WIDTH-1] ? DATA_WIDTH'(-i_x[i]) : DATA_WIDTH'(i_x[i]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
        end
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        for (int i = 0; i < ROOT_BITS; i++) begin
            r_rem[i]  <= n_rem[i];
            r_root[i] <= n_root[i];
            r_rad[i]  <= n_rad[i];
        end
    end

    // Each stage brings in two radicand bits and decides one root bit.
    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
        logic [REM_W-1:0]     rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [RAD_W-1:0]     rad_in;
        logic [REM_W-1:0]     cur;
        logic [REM_W-1:0]     trial;
        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'(r_sum);
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
        end
        assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign n_rem[g]  = (cur >= trial) ? cur - trial : cur;
        assign n_root[g] = {root_in[ROOT_BITS-2:0], (cur >= trial)};
        assign n_rad[g]  = rad_in << 2;
    end

    assign root  = r_root[ROOT_BITS-1];
    assign o_len = (root[ROOT_BITS-1:SCALE_WIDTH] != '0) ? '1 : root[SCALE_WIDTH-1:0];

endmodule

// File: hw/rtl/tdc_div.sv
// Pipelined restoring divider for the row normalization, one quotient bit per stage.
module tdc_div (
    input  logic                             i_clk,
    input  tdc_pkg::t_data                   i_num,
    input  logic [tdc_pkg::SCALE_WIDTH-1:0]  i_den,
    output logic [tdc_pkg::QUOT_WIDTH-1:0]   o_quot
);
    import tdc_pkg::*;

    localparam int DIVD_W = DATA_WIDTH + FRAC_BITS;
    localparam int REM_W  = SCALE_WIDTH;

    logic [DATA_WIDTH-1:0]  mag;
    logic [DIVD_W-1:0]      divd;
    logic [REM_W-1:0]       r_rem [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   r_low [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   r_q   [QUOT_BITS+1];
    logic [REM_W-1:0]       r_den [QUOT_BITS+1];
    logic                   r_neg [QUOT_BITS+1];
    logic [REM_W-1:0]       n_rem [QUOT_BITS];
    logic [QUOT_BITS-1:0]   n_q   [QUOT_BITS];

    assign mag  = i_num[DATA_WIDTH-1] ? DATA_WIDTH'(-i_num) : DATA_WIDTH'(i_num);
    assign divd = {mag, {FRAC_BITS{1'b0}}};

    // The quotient stays below 2^QUOT_BITS, so the top part starts below the divisor.
    for (genvar g = 0; g < QUOT_BITS; g++) begin : g_stage
        logic [REM_W:0] cur;
        assign cur      = {r_rem[g], r_low[g][QUOT_BITS-1]};
        assign n_rem[g] = (cur >= {1'b0, r_den[g]}) ? REM_W'(cur - {1'b0, r_den[g]})
                                                    : cur[REM_W-1:0];
        assign n_q[g]   = {r_q[g][QUOT_BITS-2:0], (cur >= {1'b0, r_den[g]})};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= REM_W'(divd[DIVD_W-1:QUOT_BITS]);
        r_low[0] <= divd[QUOT_BITS-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_num[DATA_WIDTH-1];
        for (int i = 0; i < QUOT_BITS; i++) begin
            r_rem[i+1] <= n_rem[i];
            r_low[i+1] <= r_low[i] << 1;
            r_q[i+1]   <= n_q[i];
            r_den[i+1] <= r_den[i];
            r_neg[i+1] <= r_neg[i];
        end
    end

    assign o_quot = r_neg[QUOT_BITS] ? -{1'b0, r_q[QUOT_BITS]} : {1'b0, r_q[QUOT_BITS]};

endmodule

// File: hw/rtl/tdc_cross.sv
// Two-stage fixed-point cross product: registered products, then floor-shifted differences.
module tdc_cross #(
    parameter int IN_W = 19
) (
    input  logic                                            i_clk,
    input  logic [2:0][IN_W-1:0]                            i_x,
    input  logic [2:0][IN_W-1:0]                            i_y,
    output logic [2:0][2*IN_W+1-tdc_pkg::FRAC_BITS-1:0]     o_c
);
    import tdc_pkg::*;

    localparam int PROD_W = 2 * IN_W;
    localparam int DIFF_W = PROD_W + 1;
    localparam int OUT_W  = DIFF_W - FRAC_BITS;

    logic signed [PROD_W-1:0] r_p [6];
    logic signed [DIFF_W-1:0] diff [3];
    logic [2:0][OUT_W-1:0]    r_c;

    always_ff @(posedge i_clk) begin
        r_p[0] <= $signed(i_x[1]) * $signed(i_y[2]);
        r_p[1] <= $signed(i_x[2]) * $signed(i_y[1]);
        r_p[2] <= $signed(i_x[2]) * $signed(i_y[0]);
        r_p[3] <= $signed(i_x[0]) * $signed(i_y[2]);
        r_p[4] <= $signed(i_x[0]) * $signed(i_y[1]);
        r_p[5] <= $signed(i_x[1]) * $signed(i_y[0]);
    end

    for (genvar i = 0; i < 3; i++) begin : g_diff
        assign diff[i] = DIFF_W'(r_p[2*i]) - DIFF_W'(r_p[2*i+1]);
    end

    // Dropping the low bits of a two's-complement value rounds toward minus infinity.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= diff[i][DIFF_W-1:FRAC_BITS];
        end
    end

    assign o_c = r_c;

endmodule

// File: hw/rtl/transform_decompose.sv
// Affine transform decomposition into rotation rows, signed scales and translation.
// The three row results of a request come out one per cycle, x row first.
// A new request waits until busy clears; the single result port carries three rows each.
// Every stage is fully pipelined, so requests overlap; busy goes high after each request.
// Reset is synchronous, active low; it clears control state and sets zero_threshold to 1.
// The receiver cannot stall; each result is shown for exactly one cycle with o_strobe.
module transform_decompose (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tdc_pkg::THR_WIDTH-1:0]   i_cfg_wr_data,
    input  logic                            start,
    input  tdc_pkg::t_req                   i_req,
    output logic                            busy,
    output logic                            o_strobe,
    output tdc_pkg::t_result                o_result
);
    import tdc_pkg::*;

    // Stage numbers count cycles after the request register.
    localparam int LEN_LAT    = 2 + ROOT_BITS;
    localparam int DIV_LAT    = 1 + QUOT_BITS;
    localparam int SIDE_DEPTH = DIV_LAT + 5;
    localparam int LAST_STAGE = LEN_LAT + DIV_LAT + 7;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int DOT_W      = PROD_W + 2;
    localparam logic [1:0] COOL_CYCLES = 2'd2;
    localparam logic [1:0] PEND_ROWS   = 2'd2;

    typedef struct packed {
        t_req                         item;
        logic [2:0][SCALE_WIDTH-1:0]  scale;
        logic                         ok;
    } t_side;

    logic                         accept;
    logic [THR_WIDTH-1:0]         r_thr;
    logic [1:0]                   r_cool;
    t_req                         r_in;
    logic [LAST_STAGE:0]          r_vpipe;
    t_data                        in_row [3][3];
    logic [2:0][SCALE_WIDTH-1:0]  len;
    logic                         ok_now;
    t_req                         req_len;
    t_side                        side_len;
    t_side                        side_dot;
    t_side                        side_out;
    t_data                        len_row [3][3];
    logic [2:0][QUOT_WIDTH-1:0]   at_q;
    logic [2:0][QUOT_WIDTH-1:0]   tr_q;
    logic [2:0][QUOT_WIDTH-1:0]   at_d2;
    logic [2:0][QUOT_WIDTH-1:0]   at_d4;
    logic [2:0][UP_WIDTH-1:0]     at_ext;
    logic [2:0][UP_WIDTH-1:0]     up;
    logic [2:0][UP_WIDTH-1:0]     up_d2;
    logic [2:0][RIGHT_WIDTH-1:0]  rt;
    t_data                        r_rot   [3][3];
    t_data                        r_rot_a [3][3];
    t_data                        r_rot_b [3][3];
    t_data                        dot_row [3][3];
    logic signed [PROD_W-1:0]     r_prod  [3][3];
    logic signed [DOT_W-1:0]      dot     [3];
    logic [2:0]                   r_neg;
    t_data                        trans   [3];
    t_result                      res     [3];
    t_result                      r_result;
    t_result                      r_pend  [2];
    logic [1:0]                   r_cnt;
    logic                         r_strobe;

    // A request is taken only outside the cool-down window, which keeps the
    // output bursts of consecutive matrices, three rows each, from overlapping.
    assign accept = start && !busy;
    assign busy   = (r_cool != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_WIDTH'(1);
            r_cool  <= '0;
            r_vpipe <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (accept) begin
                r_cool <= COOL_CYCLES;
            end else if (r_cool != '0) begin
                r_cool <= r_cool - 2'd1;
            end
            r_vpipe <= {r_vpipe[LAST_STAGE-1:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
    end

    assign in_row[0] = '{r_in.a00, r_in.a01, r_in.a02};
    assign in_row[1] = '{r_in.a10, r_in.a11, r_in.a12};
    assign in_row[2] = '{r_in.a20, r_in.a21, r_in.a22};

    // Three row lanes compute the scales side by side.
    for (genvar k = 0; k < 3; k++) begin : g_len
        tdc_row_len u_len (
            .i_clk (i_clk),
            .i_x   (in_row[k]),
            .o_len (len[k])
        );
    end

    // The raw matrix rides alongside the square-root pipeline.
    tdc_delay #(.WIDTH($bits(t_req)), .DEPTH(LEN_LAT)) u_dly_req (
        .i_clk (i_clk),
        .i_d   (r_in),
        .o_q   (req_len)
    );

    // Merge point for the lanes: every scale must clear the zero threshold.
    assign ok_now = (len[0] > SCALE_WIDTH'(r_thr)) && (len[1] > SCALE_WIDTH'(r_thr)) &&
                    (len[2] > SCALE_WIDTH'(r_thr));

    assign len_row[0] = '{req_len.a00, req_len.a01, req_len.a02};
    assign len_row[1] = '{req_len.a10, req_len.a11, req_len.a12};
    assign len_row[2] = '{req_len.a20, req_len.a21, req_len.a22};

    always_comb begin
        side_len.item  = req_len;
        side_len.scale = len;
        side_len.ok    = ok_now;
    end

    // The forward axis comes from row 2 and the provisional right axis from row 0.
    // With a zero scale the quotients are meaningless, but they are discarded later.
    for (genvar j = 0; j < 3; j++) begin : g_div
        tdc_div u_div_at (
            .i_clk  (i_clk),
            .i_num  (len_row[2][j]),
            .i_den  (len[2]),
            .o_quot (at_q[j])
        );
        tdc_div u_div_tr (
            .i_clk  (i_clk),
            .i_num  (len_row[0][j]),
            .i_den  (len[0]),
            .o_quot (tr_q[j])
        );
        assign at_ext[j] = UP_WIDTH'($signed(at_d2[j]));
    end

    // up = at x tempRight
    tdc_cross #(.IN_W(QUOT_WIDTH)) u_cross_up (
        .i_clk (i_clk),
        .i_x   (at_q),
        .i_y   (tr_q),
        .o_c   (up)
    );

    tdc_delay #(.WIDTH(3 * QUOT_WIDTH), .DEPTH(2)) u_dly_at2 (
        .i_clk (i_clk),
        .i_d   (at_q),
        .o_q   (at_d2)
    );

    // right = up x at, left unnormalized.
    tdc_cross #(.IN_W(UP_WIDTH)) u_cross_rt (
        .i_clk (i_clk),
        .i_x   (up),
        .i_y   (at_ext),
        .o_c   (rt)
    );

    tdc_delay #(.WIDTH(3 * QUOT_WIDTH), .DEPTH(2)) u_dly_at4 (
        .i_clk (i_clk),
        .i_d   (at_d2),
        .o_q   (at_d4)
    );

    tdc_delay #(.WIDTH(3 * UP_WIDTH), .DEPTH(2)) u_dly_up2 (
        .i_clk (i_clk),
        .i_d   (up),
        .o_q   (up_d2)
    );

    tdc_delay #(.WIDTH($bits(t_side)), .DEPTH(SIDE_DEPTH)) u_dly_side (
        .i_clk (i_clk),
        .i_d   (side_len),
        .o_q   (side_dot)
    );

    tdc_delay #(.WIDTH($bits(t_side)), .DEPTH(2)) u_dly_out (
        .i_clk (i_clk),
        .i_d   (side_dot),
        .o_q   (side_out)
    );

    assign dot_row[0] = '{side_dot.item.a00, side_dot.item.a01, side_dot.item.a02};
    assign dot_row[1] = '{side_dot.item.a10, side_dot.item.a11, side_dot.item.a12};
    assign dot_row[2] = '{side_dot.item.a20, side_dot.item.a21, side_dot.item.a22};

    // Saturate the rotation rows, then test each against its original row for a
    // reflection: a negative dot product flips the sign of that axis' scale.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_rot[0][j] <= sat_data(64'($signed(rt[j])));
            r_rot[1][j] <= sat_data(64'($signed(up_d2[j])));
            r_rot[2][j] <= sat_data(64'($signed(at_d4[j])));
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[k][j]  <= PROD_W'(r_rot[k][j]) * PROD_W'(dot_row[k][j] >>> DOT_SHIFT);
                r_rot_a[k][j] <= r_rot[k][j];
                r_rot_b[k][j] <= r_rot_a[k][j];
            end
            r_neg[k] <= dot[k][DOT_W-1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_dot
        assign dot[k] = DOT_W'(r_prod[k][0]) + DOT_W'(r_prod[k][1]) + DOT_W'(r_prod[k][2]);
    end

    assign trans[0] = side_out.item.tx;
    assign trans[1] = side_out.item.ty;
    assign trans[2] = side_out.item.tz;

    // Build the three results. A zero scale falls back to the identity rotation
    // with the plain, never negated, scale lengths.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            res[k].row       = ROW_WIDTH'(k);
            res[k].rot_x     = side_out.ok ? r_rot_b[k][0] : ((k == 0) ? ROT_ONE : '0);
            res[k].rot_y     = side_out.ok ? r_rot_b[k][1] : ((k == 1) ? ROT_ONE : '0);
            res[k].rot_z     = side_out.ok ? r_rot_b[k][2] : ((k == 2) ? ROT_ONE : '0);
            res[k].scale_out = (side_out.ok && r_neg[k]) ? -DATA_WIDTH'(side_out.scale[k])
                                                         : DATA_WIDTH'(side_out.scale[k]);
            res[k].trans_out = trans[k];
            res[k].ok        = side_out.ok;
            res[k].last      = (ROW_WIDTH'(k) == ROW_Z);
        end
    end

    // Output serializer: the x row is registered out directly, and y and z follow
    // in that order from a two-entry holding line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else if (r_vpipe[LAST_STAGE]) begin
            r_cnt    <= PEND_ROWS;
            r_strobe <= 1'b1;
        end else if (r_cnt != '0) begin
            r_cnt    <= r_cnt - 2'd1;
            r_strobe <= 1'b1;
        end else begin
            r_strobe <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vpipe[LAST_STAGE]) begin
            r_result  <= res[0];
            r_pend[0] <= res[1];
            r_pend[1] <= res[2];
        end else if (r_cnt != '0) begin
            r_result  <= r_pend[0];
            r_pend[0] <= r_pend[1];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after a request");

    a_y_follows_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.row == ROW_X) |=> (o_strobe && o_result.row == ROW_Y))
        else $error("row y did not follow row x");

    a_z_follows_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.row == ROW_Y) |=>
        (o_strobe && o_result.row == ROW_Z && o_result.last))
        else $error("row z did not follow row y");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vpipe[LAST_STAGE] |-> (r_cnt == '0))
        else $error("new matrix reached the serializer while rows were pending");

    a_plain_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.ok) |-> !o_result.scale_out[DATA_WIDTH-1])
        else $error("scale negated on a zero-scale matrix");

endmodule

// File: verif/transform_decompose_test.sv
// Self-checking testbench for transform_decompose: directed and random matrices.
module transform_decompose_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdc_pkg::*;

    // The drain wait is longer than the time from a taken request to its first row
    // result, so after it nothing is still in flight.
    localparam int DRAIN_CYCLES = 80;
    // Cycles without any request taken or row result seen before the run is abandoned.
    localparam int STALL_LIMIT  = 3000;
    localparam t_data ONE_Q16   = 32'sh0001_0000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_wr_en;
    logic [15:0]     i_cfg_wr_data;
    logic            start;
    t_req            i_req;
    logic            busy;
    logic            o_strobe;
    t_result         o_result;

    transform_decompose u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .start         (start),
        .i_req         (i_req),
        .busy          (busy),
        .o_strobe      (o_strobe),
        .o_result      (o_result)
    );

    // Our own copy of the threshold register, updated with each write.
    logic [15:0] zero_thr;
    // Row results still owed by the block, oldest first.
    t_result     pending_rows[$];
    int          errors;
    bit          gaps_on;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: fixed-point TRS decomposition of one request.
    // ------------------------------------------------------------------

    // Floor square root of the exact sum of squares, saturated to the positive range.
    function automatic longint row_length(input t_data x, input t_data y, input t_data z);
        logic [67:0] sum;
        logic [67:0] cand;
        logic [33:0] root;
        sum  = 68'(longint'(x) * longint'(x)) + 68'(longint'(y) * longint'(y))
             + 68'(longint'(z) * longint'(z));
        root = '0;
        for (int b = 32; b >= 0; b--) begin
            cand = 68'(root | (34'd1 << b));
            if (cand * cand <= sum) begin
                root = cand[33:0];
            end
        end
        if (root > 34'h7FFF_FFFF) begin
            return 64'sh7FFF_FFFF;
        end
        return longint'(root);
    endfunction

    // Divide by a row length: magnitude shifted up, truncated, sign put back.
    function automatic longint norm_div(input longint a, input longint s);
        longint q;
        if (s <= 0) begin
            return 0;
        end
        q = ((a < 0 ? -a : a) <<< 16) / s;
        return (a < 0) ? -q : q;
    endfunction

    function automatic t_data clamp(input longint v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return t_data'(v);
    endfunction

    // Cross product in Q16.16; >>> on a signed longint floors toward minus infinity.
    function automatic void cross3(input longint p[3], input longint q[3],
                                   output longint c[3]);
        c[0] = (p[1] * q[2] - p[2] * q[1]) >>> 16;
        c[1] = (p[2] * q[0] - p[0] * q[2]) >>> 16;
        c[2] = (p[0] * q[1] - p[1] * q[0]) >>> 16;
    endfunction

    function automatic void predict_rows(input t_req r);
        longint  m[3][3];
        longint  len[3];
        longint  at_v[3], tr_v[3], up_v[3], rt_v[3];
        t_data   rot[3][3];
        t_data   trans[3];
        longint  dot, sc;
        bit      valid;
        t_result res;
        m[0] = '{r.a00, r.a01, r.a02};
        m[1] = '{r.a10, r.a11, r.a12};
        m[2] = '{r.a20, r.a21, r.a22};
        trans = '{r.tx, r.ty, r.tz};
        valid = 1'b1;
        for (int k = 0; k < 3; k++) begin
            len[k] = row_length(t_data'(m[k][0]), t_data'(m[k][1]), t_data'(m[k][2]));
            if (len[k] <= longint'(zero_thr)) begin
                valid = 1'b0;
            end
        end
        if (!valid) begin
            // Degenerate scale: identity rotation and unsigned lengths.
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    rot[k][j] = (k == j) ? ONE_Q16 : '0;
                end
            end
        end else begin
            for (int j = 0; j < 3; j++) begin
                at_v[j] = norm_div(m[2][j], len[2]);
                tr_v[j] = norm_div(m[0][j], len[0]);
            end
            cross3(at_v, tr_v, up_v);
            cross3(up_v, at_v, rt_v);
            for (int j = 0; j < 3; j++) begin
                rot[0][j] = clamp(rt_v[j]);
                rot[1][j] = clamp(up_v[j]);
                rot[2][j] = clamp(at_v[j]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            sc = len[k];
            if (valid) begin
                dot = 0;
                for (int j = 0; j < 3; j++) begin
                    dot += longint'(rot[k][j]) * m[k][j];
                end
                // A reflected axis shows up as a negative dot product.
                if (dot < 0) begin
                    sc = -sc;
                end
            end
            res.row       = k[1:0];
            res.rot_x     = rot[k][0];
            res.rot_y     = rot[k][1];
            res.rot_z     = rot[k][2];
            res.scale_out = t_data'(sc);
            res.trans_out = trans[k];
            res.ok        = valid;
            res.last      = (k == 2);
            pending_rows.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Row checker: every strobe must match the oldest expected row.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected row result, actual %p", $time, o_result);
            end else begin
                if (o_result !== pending_rows[0]) begin
                    errors++;
                    $display("%0t: row mismatch, expected %p, actual %p",
                             $time, pending_rows[0], o_result);
                end
                void'(pending_rows.pop_front());
            end
        end
    end

    // Watchdog: the run is abandoned when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it.
    task automatic send_matrix(input t_req r);
        int gap;
        i_req <= r;
        start <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_rows(r);
        if (gaps_on && $urandom_range(99) < 29) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let every owed row arrive, then give the pipeline time to empty.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [15:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        zero_thr = v;
    endtask

    function automatic t_req make_diag(input t_data sx, input t_data sy, input t_data sz);
        t_req r;
        r     = '0;
        r.a00 = sx;
        r.a11 = sy;
        r.a22 = sz;
        r.tx  = t_data'($urandom);
        r.ty  = t_data'($urandom);
        r.tz  = t_data'($urandom);
        return r;
    endfunction

    function automatic t_req rand_full();
        t_req r;
        r.a00 = t_data'($urandom); r.a01 = t_data'($urandom); r.a02 = t_data'($urandom);
        r.a10 = t_data'($urandom); r.a11 = t_data'($urandom); r.a12 = t_data'($urandom);
        r.a20 = t_data'($urandom); r.a21 = t_data'($urandom); r.a22 = t_data'($urandom);
        r.tx  = t_data'($urandom); r.ty  = t_data'($urandom); r.tz  = t_data'($urandom);
        return r;
    endfunction

    // Entries of moderate size keep the rotation math away from saturation,
    // which is where most realistic transforms live.
    function automatic t_req rand_moderate(input int bits);
        t_req r;
        r = rand_full();
        r.a00 = r.a00 >>> (32 - bits); r.a01 = r.a01 >>> (32 - bits);
        r.a02 = r.a02 >>> (32 - bits); r.a10 = r.a10 >>> (32 - bits);
        r.a11 = r.a11 >>> (32 - bits); r.a12 = r.a12 >>> (32 - bits);
        r.a20 = r.a20 >>> (32 - bits); r.a21 = r.a21 >>> (32 - bits);
        r.a22 = r.a22 >>> (32 - bits);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_basic_shapes();
        t_req r;
        send_matrix(make_diag(ONE_Q16, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(32'sh0002_0000, 32'sh0000_8000, 32'sh0003_0000));
        // Mirrored axes: a row whose rotation row points against it gets a negative scale.
        send_matrix(make_diag(-ONE_Q16, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(ONE_Q16, -32'sh0002_0000, -ONE_Q16));
        // A 90 degree turn about z.
        r = '0;
        r.a01 = ONE_Q16; r.a10 = -ONE_Q16; r.a22 = ONE_Q16;
        r.tx = 32'sh7FFF_FFFF; r.ty = 32'sh8000_0000; r.tz = 32'sh0;
        send_matrix(r);
    endtask

    task automatic test_zero_scale();
        send_matrix('0);
        send_matrix(make_diag(ONE_Q16, '0, ONE_Q16));
        // Lengths of exactly one and two LSBs around the reset threshold of one.
        send_matrix(make_diag(32'sd1, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(32'sd2, 32'sd2, -32'sd2));
    endtask

    task automatic test_extremes();
        t_req r;
        r = '{default: 32'sh7FFF_FFFF};
        send_matrix(r);
        r = '{default: 32'sh8000_0000};
        send_matrix(r);
        send_matrix(make_diag(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
        r = '{default: 32'shFFFF_FFFF};
        send_matrix(r);
        send_matrix(make_diag(32'sh8000_0000, -32'sd1, 32'sd1));
    endtask

    task automatic test_threshold_settings();
        set_threshold(16'd0);
        send_matrix(make_diag(32'sd1, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(32'sd1, 32'sd1, -32'sd1));
        send_matrix('0);
        set_threshold(16'hFFFF);
        send_matrix(make_diag(32'sh0000_FFFF, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(ONE_Q16, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(32'sh0001_0001, -32'sh0001_0001, 32'sh0001_0001));
        set_threshold(16'h8000);
        send_matrix(make_diag(32'sh0000_8000, ONE_Q16, ONE_Q16));
        send_matrix(make_diag(32'sh0000_8001, ONE_Q16, ONE_Q16));
    endtask

    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            // No gaps during a stretch in the middle of the run.
            gaps_on = !(n >= count / 3 && n < count / 3 + 30);
            if (n == count / 2) begin
                set_threshold(16'($urandom));
            end
            if (n == 3 * count / 4) begin
                // Hold off until the pipeline is empty, then resume.
                wait_idle();
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_matrix(rand_moderate($urandom_range(17, 24)));
            end else if (pick < 75) begin
                send_matrix(rand_full());
            end else if (pick < 90) begin
                send_matrix(rand_moderate($urandom_range(2, 16)));
            end else begin
                send_matrix(make_diag(t_data'($urandom) >>> $urandom_range(0, 31),
                                      t_data'($urandom) >>> $urandom_range(0, 31),
                                      t_data'($urandom) >>> $urandom_range(0, 31)));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        errors        = 0;
        gaps_on       = 1'b1;
        zero_thr      = 16'd1;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        start         = 1'b0;
        i_req         = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_shapes();
        test_zero_scale();
        test_extremes();
        test_threshold_settings();
        set_threshold(16'd1);
        test_random(138);

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tdc_pkg.sv
hw/rtl/tdc_delay.sv
hw/rtl/tdc_row_len.sv
hw/rtl/tdc_div.sv
hw/rtl/tdc_cross.sv
hw/rtl/transform_decompose.sv
verif/transform_decompose_test.sv
